### src/bffa_pkg.sv
// bffa_pkg: shared constants and types for the bitmap first-fit allocator
// no dependencies
package bffa_pkg;
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_INODE = 2'd2;
    localparam logic [1:0] MODE_SECT  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_CONFLICT = 2'd2;

    localparam logic [1:0] REG_INODE_BYTES = 2'd0;
    localparam logic [1:0] REG_SECT_BYTES  = 2'd1;
    localparam logic [1:0] REG_FIRST_DATA  = 2'd2;

    localparam logic [7:0] FULL_BYTE = 8'hff;

    typedef logic [7:0] t_byte;
endpackage

### src/bffa_ram.sv
// bffa_ram: byte-wide single-port bitmap store with a registered read
// depends on bffa_pkg
module bffa_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_addr,
    input  bffa_pkg::t_byte   i_wdata,
    output bffa_pkg::t_byte   o_rdata
);
    bffa_pkg::t_byte r_mem [DEPTH];
    bffa_pkg::t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/bitmap_first_fit_allocator_core.sv
// bitmap_first_fit_allocator_core: inode and sector bitmaps with first-fit allocation
// depends on bffa_pkg and bffa_ram
//
// channel   signals                                   dir
// command   i_start/o_busy, i_mode..i_run_length     in
// result    o_done, o_status, o_allocated_number...  out
// config    i_cfg_valid/o_cfg_ready, index, data     in
//
// byte access holds busy through S_RD, S_WB and S_DONE; o_done follows in the next cycle
// allocation reads the bitmap byte by byte, waiting out each registered read: the
// scan walks from byte 0 to the first clear bit, then a sector run is checked and
// then set byte by byte, one pass each, and S_DONE finishes the command
// synchronous active-low reset clears state and done and loads the config register defaults; results cannot be stalled
module bitmap_first_fit_allocator_core #(
    parameter int INODE_MAP_BYTES  = 512,
    parameter int SECTOR_MAP_BYTES = 4096,
    parameter int MAX_RUN          = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_mode,
    input  logic        i_map_select,
    input  logic [11:0] i_byte_index,
    input  logic [7:0]  i_byte_value,
    input  logic [12:0] i_run_length,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [20:0] o_allocated_number,
    output logic [7:0]  o_read_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    localparam int IAW = (INODE_MAP_BYTES > 1) ? $clog2(INODE_MAP_BYTES) : 1;
    localparam int SAW = (SECTOR_MAP_BYTES > 1) ? $clog2(SECTOR_MAP_BYTES) : 1;
    localparam int BW  = 22;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_SET   = 3'd4;
    localparam logic [2:0] S_WB    = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]  r_state;
    logic [1:0]  r_mode;
    logic        r_sel;
    logic [11:0] r_idx;
    logic [7:0]  r_val;
    logic [12:0] r_len;
    logic [9:0]  r_ibytes;
    logic [12:0] r_sbytes;
    logic [19:0] r_first;
    logic [BW-1:0] r_byte;     // current byte address in scan/run
    logic [BW-1:0] r_nbytes;
    logic [BW-1:0] r_bit;      // first free bit
    logic [BW-1:0] r_end;      // run end bit (exclusive)
    logic        r_wait;
    logic [1:0]  r_status;
    logic [20:0] r_num;
    logic [7:0]  r_rd;
    logic        r_done;

    logic          ram_i_we, ram_s_we;
    logic [IAW-1:0] ram_i_addr;
    logic [SAW-1:0] ram_s_addr;
    bffa_pkg::t_byte ram_wdata, ram_i_q, ram_s_q, q;

    bffa_ram #(.DEPTH(INODE_MAP_BYTES), .AW(IAW)) u_inode (
        .i_clk(i_clk), .i_we(ram_i_we), .i_addr(ram_i_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_i_q));
    bffa_ram #(.DEPTH(SECTOR_MAP_BYTES), .AW(SAW)) u_sect (
        .i_clk(i_clk), .i_we(ram_s_we), .i_addr(ram_s_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_s_q));

    logic use_sect;
    assign use_sect = (r_mode == bffa_pkg::MODE_SECT) ||
                      ((r_mode == bffa_pkg::MODE_WRITE || r_mode == bffa_pkg::MODE_READ)
                       && r_sel);
    assign q = use_sect ? ram_s_q : ram_i_q;

    // byte mask for run bits inside current byte
    logic [7:0] run_mask;
    logic [2:0] first_k;
    logic [BW-1:0] byte_lo, byte_hi;
    always_comb begin
        byte_lo = {r_byte[BW-4:0], 3'b000};
        byte_hi = byte_lo + BW'(8);
        for (int k = 0; k < 8; k++) begin
            run_mask[k] = ((byte_lo + BW'(k)) >= r_bit) && ((byte_lo + BW'(k)) < r_end);
        end
        first_k = 3'd7;
        for (int k = 7; k >= 0; k--) begin
            if (!q[k]) first_k = 3'(k);
        end
    end

    logic in_map, idx_ok;
    assign idx_ok = r_sel ? ({10'd0, r_idx} < BW'(SECTOR_MAP_BYTES))
                          : ({10'd0, r_idx} < BW'(INODE_MAP_BYTES));

    always_comb begin
        ram_i_we   = 1'b0;
        ram_s_we   = 1'b0;
        ram_wdata  = r_val;
        ram_i_addr = IAW'(r_byte);
        ram_s_addr = SAW'(r_byte);
        in_map     = r_byte < r_nbytes;
        if (r_state == S_RD && r_mode == bffa_pkg::MODE_WRITE && idx_ok) begin
            ram_i_we = !r_sel;
            ram_s_we = r_sel;
        end
        if (r_state == S_SCAN && !r_wait && q != bffa_pkg::FULL_BYTE
                && r_mode == bffa_pkg::MODE_INODE) begin
            ram_wdata = q | (8'd1 << first_k);
            ram_i_we  = 1'b1;
        end
        if (r_state == S_SET && !r_wait) begin
            ram_wdata = q | run_mask;
            ram_s_we  = 1'b1;
        end
    end

    assign o_busy      = r_state != S_IDLE;
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_allocated_number = r_num;
    assign o_read_byte = r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_ibytes <= 10'd512;
            r_sbytes <= 13'd4096;
            r_first  <= 20'd0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    bffa_pkg::REG_INODE_BYTES: r_ibytes <= i_cfg_data[9:0];
                    bffa_pkg::REG_SECT_BYTES:  r_sbytes <= i_cfg_data[12:0];
                    bffa_pkg::REG_FIRST_DATA:  r_first  <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mode   <= i_mode;
                        r_sel    <= i_map_select;
                        r_idx    <= i_byte_index;
                        r_val    <= i_byte_value;
                        r_len    <= i_run_length;
                        r_num    <= 21'd0;
                        r_rd     <= 8'd0;
                        r_wait   <= 1'b1;
                        if (i_mode == bffa_pkg::MODE_INODE) begin
                            r_status <= bffa_pkg::ST_OK;
                            r_byte   <= '0;
                            r_nbytes <= ({12'd0, r_ibytes} > BW'(INODE_MAP_BYTES))
                                ? BW'(INODE_MAP_BYTES) : {12'd0, r_ibytes};
                            r_state  <= S_SCAN;
                        end else if (i_mode == bffa_pkg::MODE_SECT) begin
                            r_byte   <= '0;
                            r_nbytes <= ({9'd0, r_sbytes} > BW'(SECTOR_MAP_BYTES))
                                ? BW'(SECTOR_MAP_BYTES) : {9'd0, r_sbytes};
                            if (i_run_length == 13'd0) begin
                                r_status <= bffa_pkg::ST_OK;
                                r_state  <= S_DONE;
                            end else if ({9'd0, i_run_length} > BW'(MAX_RUN)) begin
                                r_status <= bffa_pkg::ST_CONFLICT;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= bffa_pkg::ST_OK;
                                r_state  <= S_SCAN;
                            end
                        end else begin
                            r_status <= bffa_pkg::ST_OK;
                            r_byte   <= {10'd0, i_byte_index};
                            r_state  <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (r_mode == bffa_pkg::MODE_READ && idx_ok) r_rd <= q;
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    if (!in_map) begin
                        r_status <= bffa_pkg::ST_FULL;
                        r_state  <= S_DONE;
                    end else if (r_wait) begin
                        r_wait <= 1'b0;
                    end else if (q == bffa_pkg::FULL_BYTE) begin
                        r_byte <= r_byte + BW'(1);
                        r_wait <= 1'b1;
                    end else begin
                        r_bit <= byte_lo + BW'(first_k);
                        if (r_mode == bffa_pkg::MODE_INODE) begin
                            r_num   <= 21'(byte_lo + BW'(first_k));
                            r_state <= S_DONE;
                        end else begin
                            r_end   <= byte_lo + BW'(first_k) + BW'(r_len);
                            r_wait  <= 1'b1;
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    if (r_byte >= r_nbytes) begin
                        r_status <= bffa_pkg::ST_CONFLICT;
                        r_state  <= S_DONE;
                    end else if (r_wait) begin
                        r_wait <= 1'b0;
                    end else if ((q & run_mask) != 8'd0) begin
                        r_status <= bffa_pkg::ST_CONFLICT;
                        r_state  <= S_DONE;
                    end else if (byte_hi >= r_end) begin
                        r_byte  <= r_bit >> 3;
                        r_wait  <= 1'b1;
                        r_state <= S_SET;
                    end else begin
                        r_byte <= r_byte + BW'(1);
                        r_wait <= 1'b1;
                    end
                end
                S_SET: begin
                    if (r_wait) begin
                        r_wait <= 1'b0;
                    end else if (byte_hi >= r_end) begin
                        r_num   <= 21'(r_bit - BW'(1) + {2'd0, r_first});
                        r_state <= S_DONE;
                    end else begin
                        r_byte <= r_byte + BW'(1);
                        r_wait <= 1'b1;
                    end
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### tb/tb_bitmap_first_fit_allocator_core.sv
// tb_bitmap_first_fit_allocator_core: self-checking bench for the bitmap allocator core
// depends on bffa_pkg and bitmap_first_fit_allocator_core; a class predicts each result word
// the low bytes of both maps are written after reset, then directed and random words run
`timescale 1ns / 100ps

module tb_bitmap_first_fit_allocator_core;

    typedef struct {
        logic [1:0]  status;
        logic [20:0] number;
        logic [7:0]  rd_byte;
    } t_alloc_result;

    class alloc_scoreboard;
        bffa_pkg::t_byte inode_map [512];
        bffa_pkg::t_byte sect_map  [4096];
        logic [9:0]  inode_bytes;
        logic [12:0] sect_bytes;
        logic [19:0] first_data;
        t_alloc_result pending [$];
        int          errors;

        function new();
            inode_bytes = 10'd512;
            sect_bytes  = 13'd4096;
            first_data  = 20'd0;
            errors      = 0;
            foreach (inode_map[i]) inode_map[i] = '0;
            foreach (sect_map[i]) sect_map[i] = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [19:0] data);
            case (idx)
                bffa_pkg::REG_INODE_BYTES: inode_bytes = data[9:0];
                bffa_pkg::REG_SECT_BYTES:  sect_bytes  = data[12:0];
                bffa_pkg::REG_FIRST_DATA:  first_data  = data;
                default: ;
            endcase
        endfunction

        function void note(logic [1:0] mode, logic sel, logic [11:0] idx,
                           logic [7:0] val, logic [12:0] len);
            t_alloc_result r;
            int nbytes;
            int bitpos;
            bit found;
            bit clash;
            r.status  = bffa_pkg::ST_OK;
            r.number  = '0;
            r.rd_byte = '0;
            bitpos = 0;
            found  = 0;
            clash  = 0;
            if (mode == bffa_pkg::MODE_WRITE || mode == bffa_pkg::MODE_READ) begin
                if (sel) begin
                    if (mode == bffa_pkg::MODE_WRITE) sect_map[idx] = val;
                    else r.rd_byte = sect_map[idx];
                end else if (idx < 512) begin
                    if (mode == bffa_pkg::MODE_WRITE) inode_map[idx] = val;
                    else r.rd_byte = inode_map[idx];
                end
            end else if (mode == bffa_pkg::MODE_INODE) begin
                nbytes = (inode_bytes > 512) ? 512 : int'(inode_bytes);
                for (int i = 0; i < nbytes && !found; i++) begin
                    if (inode_map[i] != bffa_pkg::FULL_BYTE) begin
                        for (int k = 0; k < 8 && !found; k++) begin
                            if (!inode_map[i][k]) begin
                                found = 1;
                                bitpos = i * 8 + k;
                            end
                        end
                    end
                end
                if (found) begin
                    inode_map[bitpos >> 3][bitpos & 7] = 1'b1;
                    r.number = 21'(bitpos);
                end else begin
                    r.status = bffa_pkg::ST_FULL;
                end
            end else begin
                nbytes = (sect_bytes > 4096) ? 4096 : int'(sect_bytes);
                if (len == 0) begin
                end else if (len > 4096) begin
                    r.status = bffa_pkg::ST_CONFLICT;
                end else begin
                    for (int i = 0; i < nbytes && !found; i++) begin
                        if (sect_map[i] != bffa_pkg::FULL_BYTE) begin
                            for (int k = 0; k < 8 && !found; k++) begin
                                if (!sect_map[i][k]) begin
                                    found = 1;
                                    bitpos = i * 8 + k;
                                end
                            end
                        end
                    end
                    if (!found) begin
                        r.status = bffa_pkg::ST_FULL;
                    end else begin
                        for (int i = 0; i < len && !clash; i++) begin
                            if (bitpos + i >= nbytes * 8 ||
                                sect_map[(bitpos + i) >> 3][(bitpos + i) & 7])
                                clash = 1;
                        end
                        if (clash) begin
                            r.status = bffa_pkg::ST_CONFLICT;
                        end else begin
                            for (int i = 0; i < len; i++)
                                sect_map[(bitpos + i) >> 3][(bitpos + i) & 7] = 1'b1;
                            r.number = 21'(bitpos) - 21'd1 + 21'(first_data);
                        end
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check(logic [1:0] status, logic [20:0] number, logic [7:0] rd_byte);
            t_alloc_result e;
            if (pending.size() == 0) begin
                $error("unexpected result word: status %0d number %0d byte %0d",
                       status, number, rd_byte);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                errors++;
            end
            if (number !== e.number) begin
                $error("allocated_number: expected %0d, got %0d", e.number, number);
                errors++;
            end
            if (rd_byte !== e.rd_byte) begin
                $error("read_byte: expected %0d, got %0d", e.rd_byte, rd_byte);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_mode;
    logic        i_map_select;
    logic [11:0] i_byte_index;
    logic [7:0]  i_byte_value;
    logic [12:0] i_run_length;
    logic        o_done;
    logic [1:0]  o_status;
    logic [20:0] o_allocated_number;
    logic [7:0]  o_read_byte;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [19:0] i_cfg_data;

    alloc_scoreboard sb;
    int idle_pct;
    int stall_count;

    localparam int STALL_LIMIT = 200000;
    localparam int FILL_BYTES  = 64;

    bitmap_first_fit_allocator_core dut (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_mode, .i_map_select,
        .i_byte_index, .i_byte_value, .i_run_length, .o_done, .o_status,
        .o_allocated_number, .o_read_byte, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_index, .i_cfg_data
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check(o_status, o_allocated_number, o_read_byte);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !o_busy) || (i_cfg_valid && o_cfg_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    task automatic send(logic [1:0] mode, logic sel, logic [11:0] idx,
                        logic [7:0] val, logic [12:0] len);
        if ($urandom_range(99) < idle_pct)
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        i_mode       = mode;
        i_map_select = sel;
        i_byte_index = idx;
        i_byte_value = val;
        i_run_length = len;
        i_start      = 1'b1;
        do @(posedge i_clk); while (o_busy);
        sb.note(mode, sel, idx, val, len);
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [19:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(logic [19:0] ib, logic [19:0] sbytes, logic [19:0] fds);
        drain();
        cfg_write(bffa_pkg::REG_INODE_BYTES, ib);
        cfg_write(bffa_pkg::REG_SECT_BYTES, sbytes);
        cfg_write(bffa_pkg::REG_FIRST_DATA, fds);
    endtask

    function automatic logic [7:0] fill_byte();
        return ($urandom_range(3) == 0) ? bffa_pkg::FULL_BYTE : 8'($urandom);
    endfunction

    task automatic random_word(int span);
        int pick;
        logic [12:0] len;
        pick = $urandom_range(99);
        if (pick < 25) begin
            if ($urandom_range(9) == 0)
                send(bffa_pkg::MODE_WRITE, 1'($urandom), 12'($urandom), 8'($urandom),
                     13'($urandom));
            else
                send(bffa_pkg::MODE_WRITE, 1'($urandom), 12'($urandom_range(span - 1)),
                     ($urandom_range(1) ? 8'h00 : fill_byte()), 13'($urandom));
        end else if (pick < 45) begin
            if ($urandom_range(4) == 0)
                send(bffa_pkg::MODE_READ, 1'b0, 12'($urandom_range(512, 4095)),
                     8'($urandom), 13'($urandom));
            else
                send(bffa_pkg::MODE_READ, 1'($urandom), 12'($urandom_range(span - 1)),
                     8'($urandom), 13'($urandom));
        end else if (pick < 70) begin
            send(bffa_pkg::MODE_INODE, 1'($urandom), 12'($urandom), 8'($urandom),
                 13'($urandom));
        end else begin
            case ($urandom_range(19))
                0:       len = 13'd0;
                1:       len = 13'($urandom_range(4097, 8191));
                2:       len = 13'($urandom_range(1, 4096));
                default: len = 13'($urandom_range(1, 16));
            endcase
            send(bffa_pkg::MODE_SECT, 1'($urandom), 12'($urandom), 8'($urandom), len);
        end
    endtask

    initial begin
        sb           = new();
        idle_pct     = 0;
        stall_count  = 0;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_mode       = bffa_pkg::MODE_WRITE;
        i_map_select = 1'b0;
        i_byte_index = '0;
        i_byte_value = '0;
        i_run_length = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = bffa_pkg::REG_INODE_BYTES;
        i_cfg_data   = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < FILL_BYTES; i++)
            send(bffa_pkg::MODE_WRITE, 1'b0, 12'(i), fill_byte(), '0);
        for (int i = 0; i < FILL_BYTES; i++)
            send(bffa_pkg::MODE_WRITE, 1'b1, 12'(i), fill_byte(), '0);

        // directed corners under reset settings
        send(bffa_pkg::MODE_WRITE, 1'b0, 12'd4095, 8'hff, 13'h1fff);
        send(bffa_pkg::MODE_READ, 1'b0, 12'd4095, 8'h00, '0);
        send(bffa_pkg::MODE_WRITE, 1'b0, 12'd511, 8'h5a, '0);
        send(bffa_pkg::MODE_READ, 1'b0, 12'd511, 8'h00, '0);
        send(bffa_pkg::MODE_WRITE, 1'b1, 12'd4095, 8'ha5, '0);
        send(bffa_pkg::MODE_READ, 1'b1, 12'd4095, 8'h00, '0);
        send(bffa_pkg::MODE_WRITE, 1'b1, 12'd0, 8'h00, '0);
        send(bffa_pkg::MODE_WRITE, 1'b1, 12'd1, 8'hf0, '0);
        send(bffa_pkg::MODE_SECT, 1'b0, '0, '0, 13'd1);
        send(bffa_pkg::MODE_SECT, 1'b0, '0, '0, 13'd0);
        send(bffa_pkg::MODE_SECT, 1'b0, '0, '0, 13'h1fff);
        send(bffa_pkg::MODE_SECT, 1'b0, '0, '0, 13'd4097);
        send(bffa_pkg::MODE_SECT, 1'b0, '0, '0, 13'd4096);
        send(bffa_pkg::MODE_WRITE, 1'b0, 12'd0, 8'h00, '0);
        send(bffa_pkg::MODE_INODE, 1'b0, '0, '0, '0);
        send(bffa_pkg::MODE_INODE, 1'b1, 12'hfff, 8'hff, 13'h1fff);
        send(bffa_pkg::MODE_READ, 1'b1, 12'd1, 8'hff, '0);
        send(bffa_pkg::MODE_SECT, 1'b0, '0, '0, 13'd8);

        set_config(20'd0, 20'd0, 20'd1);
        send(bffa_pkg::MODE_INODE, 1'b0, '0, '0, '0);
        send(bffa_pkg::MODE_SECT, 1'b0, '0, '0, 13'd1);
        set_config(20'd1, 20'd1, 20'hfffff);
        send(bffa_pkg::MODE_WRITE, 1'b1, 12'd0, 8'h00, '0);
        send(bffa_pkg::MODE_SECT, 1'b0, '0, '0, 13'd9);
        send(bffa_pkg::MODE_SECT, 1'b0, '0, '0, 13'd8);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_config(20'd16, 20'd32, 20'hfffff);
                1: set_config(20'd64, 20'd64, 20'($urandom));
                2: set_config(20'hffc08, 20'h0e040, 20'($urandom));
                3: set_config(20'($urandom_range(1, 64)), 20'($urandom_range(1, 64)),
                              20'($urandom));
                default: set_config(20'd64, 20'd64, 20'd0);
            endcase
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 64;
                2: idle_pct = 0;
                default: idle_pct = 35;
            endcase
            for (int n = 0; n < 100; n++)
                random_word(FILL_BYTES);
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
